// File: design/prc_pkg.sv
// Package for the point range count unit.
// Holds the shared widths, request codes and the token that travels the cell chain.
// No dependencies.
package prc_pkg;

	localparam int DATA_W         = 32;
	localparam int TOTAL_W        = 11;
	localparam int MAX_POINTS_DEF = 1024;

	localparam logic REQ_LOAD  = 1'b0;
	localparam logic REQ_QUERY = 1'b1;

	// One item as it moves from cell to cell; the running count and the
	// store size snapshot travel beside it because their widths follow the
	// store depth.
	typedef struct packed {
		logic                     vld;
		logic                     qry;
		logic signed [DATA_W-1:0] lo;
		logic signed [DATA_W-1:0] hi;
		logic                     lo_open;
		logic                     hi_open;
		logic                     full;
	} prc_token_t;

endpackage

// File: design/prc_cell.sv
// One cell of the point chain: holds a single stored point and adds its hit to a passing query.
// Depends on prc_pkg.
module prc_cell import prc_pkg::*; #(
	parameter int MAX_POINTS = MAX_POINTS_DEF,
	parameter int IDX        = 0
) (
	input  logic                                              clk,
	input  logic                                              arst_n,
	input  logic                                              adv,
	input  logic                                              wr_en,
	input  logic [((MAX_POINTS > 1) ? $clog2(MAX_POINTS) : 1)-1:0] wr_addr,
	input  logic signed [DATA_W-1:0]                          wr_data,
	input  prc_token_t                                        tok_in,
	input  logic [$clog2(MAX_POINTS + 1)-1:0]                 total_in,
	input  logic [$clog2(MAX_POINTS + 1)-1:0]                 limit_in,
	output prc_token_t                                        tok_out,
	output logic [$clog2(MAX_POINTS + 1)-1:0]                 total_out,
	output logic [$clog2(MAX_POINTS + 1)-1:0]                 limit_out
);

	localparam int IDX_W = (MAX_POINTS > 1) ? $clog2(MAX_POINTS) : 1;
	localparam int CNT_W = $clog2(MAX_POINTS + 1);

	logic signed [DATA_W-1:0] point_q;
	logic                     vld_q;
	prc_token_t               tok_q;
	logic [CNT_W-1:0]         total_q;
	logic [CNT_W-1:0]         limit_q;
	logic                     above;
	logic                     below;
	logic                     hit;

	// Only cells below the store size seen when the query entered take part;
	// those cells are never rewritten afterwards, as the store only appends.
	always_comb begin
		above = tok_in.lo_open ? ($signed(point_q) > $signed(tok_in.lo))
		                       : ($signed(point_q) >= $signed(tok_in.lo));
		below = tok_in.hi_open ? ($signed(point_q) < $signed(tok_in.hi))
		                       : ($signed(point_q) <= $signed(tok_in.hi));
		hit   = tok_in.qry && (CNT_W'(IDX) < limit_in) && above && below;
	end

	always_ff @(posedge clk) begin
		if (wr_en && (wr_addr == IDX_W'(IDX))) begin
			point_q <= wr_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= 1'b0;
		end else if (adv) begin
			vld_q <= tok_in.vld;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			tok_q   <= tok_in;
			total_q <= total_in + CNT_W'(hit);
			limit_q <= limit_in;
		end
	end

	// The valid flag comes from its own reset register.
	always_comb begin
		tok_out     = tok_q;
		tok_out.vld = vld_q;
	end

	assign total_out = total_q;
	assign limit_out = limit_q;

endmodule

// File: design/point_range_count_unit.sv
// Top level of the point range count unit: store size counter, chain of point cells, output register.
// Depends on prc_pkg and prc_cell.
//
// The unit keeps up to MAX_POINTS signed 32-bit points, one in each cell of a
// chain of MAX_POINTS cells, and answers each beat with exactly one result beat.
// A load beat (req_type low) appends first_value at the next free cell and
// reports the number of points now held; when the store is already full the
// point is dropped, the count is reported unchanged and store_full is raised.
// A query beat (req_type high) counts the stored points between first_value
// and upper_bound, each bound excluded when its open flag is set; an empty or
// inverted interval simply counts zero. Every beat, load or query, walks the
// whole chain one cell per cycle while the chain is not halted and picks up
// each cell's hit on the way, then passes through the output register; a new
// beat can be accepted every cycle unless the chain is halted. Results leave
// in the order the beats arrived. The chain only halts when a finished result
// is waiting in the output register and the next one has reached the end of
// the chain. A query sees exactly the points stored before it was accepted,
// even if loads follow it closely. No clearing pass is needed after reset:
// cells beyond the store size are simply ignored.
module point_range_count_unit import prc_pkg::*; #(
	parameter int MAX_POINTS = MAX_POINTS_DEF
) (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     in_valid,
	output logic                     in_ready,
	input  logic                     req_type,
	input  logic signed [DATA_W-1:0] first_value,
	input  logic signed [DATA_W-1:0] upper_bound,
	input  logic                     lower_open,
	input  logic                     upper_open,
	output logic                     out_valid,
	input  logic                     out_ready,
	output logic [TOTAL_W-1:0]       point_total,
	output logic                     store_full
);

	localparam int IDX_W = (MAX_POINTS > 1) ? $clog2(MAX_POINTS) : 1;
	localparam int CNT_W = $clog2(MAX_POINTS + 1);

	// Chain links: element 0 is the incoming beat, element MAX_POINTS the tail.
	prc_token_t       tok_c   [MAX_POINTS+1];
	logic [CNT_W-1:0] total_c [MAX_POINTS+1];
	logic [CNT_W-1:0] limit_c [MAX_POINTS+1];

	logic [CNT_W-1:0] count_q;
	logic             adv;
	logic             accept;
	logic             room;
	logic             wr_en;

	logic                     out_vld_q;
	logic [CNT_W-1:0]         out_total_q;
	logic                     out_full_q;
	logic [CNT_W+TOTAL_W-1:0] total_ext;

	// The chain moves unless its tail holds a result that cannot yet be
	// handed to the output register.
	assign adv      = !tok_c[MAX_POINTS].vld || !out_vld_q || out_ready;
	assign in_ready = adv;
	assign accept   = in_valid && in_ready;
	assign room     = count_q < CNT_W'(MAX_POINTS);
	assign wr_en    = accept && (req_type == REQ_LOAD) && room;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
		end else if (wr_en) begin
			count_q <= count_q + CNT_W'(1);
		end
	end

	// Build the beat that enters the first cell. A load carries its finished
	// result down the chain so that it leaves in order with the queries.
	always_comb begin
		tok_c[0].vld     = accept;
		tok_c[0].qry     = (req_type == REQ_QUERY);
		tok_c[0].lo      = first_value;
		tok_c[0].hi      = upper_bound;
		tok_c[0].lo_open = lower_open;
		tok_c[0].hi_open = upper_open;
		tok_c[0].full    = (req_type == REQ_LOAD) && !room;
		limit_c[0]       = count_q;
		if (req_type == REQ_LOAD) begin
			total_c[0] = room ? (count_q + CNT_W'(1)) : count_q;
		end else begin
			total_c[0] = '0;
		end
	end

	for (genvar g = 0; g < MAX_POINTS; g++) begin : g_cell
		prc_cell #(
			.MAX_POINTS (MAX_POINTS),
			.IDX        (g)
		) u_cell (
			.clk       (clk),
			.arst_n    (arst_n),
			.adv       (adv),
			.wr_en     (wr_en),
			.wr_addr   (count_q[IDX_W-1:0]),
			.wr_data   (first_value),
			.tok_in    (tok_c[g]),
			.total_in  (total_c[g]),
			.limit_in  (limit_c[g]),
			.tok_out   (tok_c[g+1]),
			.total_out (total_c[g+1]),
			.limit_out (limit_c[g+1])
		);
	end

	// Output register: parts the consumer from the chain, so the chain keeps
	// moving while a result waits as long as nothing has reached its tail.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_vld_q <= 1'b0;
		end else if (!out_vld_q || out_ready) begin
			out_vld_q <= tok_c[MAX_POINTS].vld;
		end
	end

	always_ff @(posedge clk) begin
		if ((!out_vld_q || out_ready) && tok_c[MAX_POINTS].vld) begin
			out_total_q <= total_c[MAX_POINTS];
			out_full_q  <= tok_c[MAX_POINTS].full;
		end
	end

	// The count keeps its low bits only when the store is deeper than the
	// result field can express.
	assign total_ext   = {{TOTAL_W{1'b0}}, out_total_q};
	assign out_valid   = out_vld_q;
	assign point_total = total_ext[TOTAL_W-1:0];
	assign store_full  = out_full_q;

`ifndef ASSERT_OFF
	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CNT_W'(MAX_POINTS))
		else $error("store size exceeds its depth");

	a_load_grows: assert property (@(posedge clk) disable iff (!arst_n)
		wr_en |=> count_q == $past(count_q) + CNT_W'(1))
		else $error("accepted load did not grow the store");

	a_full_reports_depth: assert property (@(posedge clk) disable iff (!arst_n)
		(out_vld_q && out_full_q) |-> out_total_q == CNT_W'(MAX_POINTS))
		else $error("dropped load reports a store size other than full");

	a_query_within_size: assert property (@(posedge clk) disable iff (!arst_n)
		(tok_c[MAX_POINTS].vld && tok_c[MAX_POINTS].qry)
			|-> total_c[MAX_POINTS] <= limit_c[MAX_POINTS])
		else $error("query count exceeds the points it could see");

	a_stall_holds_tail: assert property (@(posedge clk) disable iff (!arst_n)
		(out_vld_q && !out_ready && tok_c[MAX_POINTS].vld)
			|=> tok_c[MAX_POINTS].vld && $stable(total_c[MAX_POINTS]))
		else $error("chain tail lost while output stalled");
`endif

endmodule
